// File: sv/edsim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edsim_pkg
// shared constants for the edit distance similarity unit: request modes,
// character and result field widths and the similarity scale
// ----------------------------------------------------------------------------

package edsim_pkg;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_APPEND = 2'd0;
   localparam mode_type MODE_QUERY  = 2'd1;
   localparam mode_type MODE_FINISH = 2'd2;
   localparam mode_type MODE_CLEAR  = 2'd3;

   localparam int CHAR_W = 21;
   localparam int DIST_W = 7;
   localparam int SIM_W  = 14;

   localparam logic [SIM_W-1:0] SIM_SCALE = 14'd10000;

endpackage

// File: sv/edsim_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edsim_ram
// single write port, single read port synchronous memory, registered read
// data, read returns the old contents on a same-address write
// ----------------------------------------------------------------------------

module edsim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   parameter int AW    = 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/edsim_sim_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edsim_sim_calc
// similarity in hundredths of a percent: one constant multiply, then a
// restoring divide by the longer length, one quotient bit per cycle
// ----------------------------------------------------------------------------

module edsim_sim_calc #(
   parameter int CW = 7,
   parameter int DW = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DW-1:0]              edit_dist,
   input  logic [CW-1:0]              maxlen,
   output logic                       done,
   output logic [edsim_pkg::SIM_W-1:0] sim
);

   localparam int SW  = edsim_pkg::SIM_W;
   localparam int PW  = CW + SW;
   localparam int STW = $clog2(SW);
   localparam logic [STW-1:0] LAST_STEP = STW'(SW - 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [STW-1:0] step_ff, step_in;
   logic [PW-1:0]  rem_ff, rem_in;
   logic [PW-1:0]  dsh_ff, dsh_in;
   logic [SW-1:0]  quo_ff, quo_in;
   logic           zero_sim;
   logic [CW-1:0]  diff;
   logic [CW-1:0]  den;

   always_comb begin
      zero_sim = (maxlen == '0) || (edit_dist > DW'(maxlen));
      diff     = maxlen - CW'(edit_dist);
      den      = (maxlen == '0) ? CW'(1) : maxlen;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = '0;
         rem_in  = zero_sim ? '0 : PW'(PW'(diff) * PW'(edsim_pkg::SIM_SCALE));
         dsh_in  = PW'(den) << (SW - 1);
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[SW-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[SW-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + STW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quo_ff  <= quo_in;
   end

   assign done = done_ff;
   assign sim  = quo_ff;

endmodule

// File: sv/edit_distance_similarity_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_similarity_unit
// levenshtein distance between a stored reference string and a streamed
// query, one dp row kept in a synchronous memory and walked once per query
// character
//
//   channel   direction   ports
//   req_      in          req_valid, req_stall, req_mode, req_char_code
//   rsp_      out         rsp_valid, rsp_stall, rsp_distance,
//                         rsp_similarity_hundredths, rsp_similarity_valid,
//                         rsp_overflow
//
// append: one reference character stored per request. query character:
// one dp cell per cycle through the row memory port, cells 0 to reference
// length. clear reference: row cells 1 to MAX_LEN rewritten. finish:
// multiply and divide, then the whole row rewritten. after reset the whole
// row is rewritten before the first request is taken. a result held by
// rsp_stall blocks only the next finish request.
// ----------------------------------------------------------------------------

module edit_distance_similarity_unit #(
   parameter int MAX_LEN = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_mode,
   input  logic [edsim_pkg::CHAR_W-1:0]      req_char_code,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [edsim_pkg::DIST_W-1:0]      rsp_distance,
   output logic [edsim_pkg::SIM_W-1:0]       rsp_similarity_hundredths,
   output logic                              rsp_similarity_valid,
   output logic                              rsp_overflow
);

   localparam int CW   = $clog2(MAX_LEN + 1);
   localparam int DW   = $clog2(2 * MAX_LEN + 1);
   localparam int RA_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CHW  = edsim_pkg::CHAR_W;
   localparam int DOW  = edsim_pkg::DIST_W;
   localparam int SW   = edsim_pkg::SIM_W;
   localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);

   localparam logic [2:0] ST_SWEEP   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_FEED    = 3'd2;
   localparam logic [2:0] ST_FIN_RD  = 3'd3;
   localparam logic [2:0] ST_FIN_D   = 3'd4;
   localparam logic [2:0] ST_CALC_GO = 3'd5;
   localparam logic [2:0] ST_CALC    = 3'd6;
   localparam logic [2:0] ST_EMIT    = 3'd7;

   logic [2:0]     state_ff, state_in;
   logic [CW-1:0]  col_ff, col_in;
   logic           issue_done_ff, issue_done_in;
   logic           rvld_ff, rvld_in;
   logic [CW-1:0]  rcol_ff, rcol_in;
   logic [DW-1:0]  left_ff, left_in;
   logic [DW-1:0]  diag_ff, diag_in;
   logic [CW-1:0]  ref_len_ff, ref_len_in;
   logic [CW-1:0]  q_len_ff, q_len_in;
   logic           ovf_ff, ovf_in;
   logic [CHW-1:0] char_ff, char_in;
   logic [DW-1:0]  dist_ff, dist_in;
   logic [CW-1:0]  maxlen_ff, maxlen_in;
   logic           sim_valid_ff, sim_valid_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [DOW-1:0] rsp_distance_ff, rsp_distance_in;
   logic [SW-1:0]  rsp_sim_ff, rsp_sim_in;
   logic           rsp_sim_valid_ff, rsp_sim_valid_in;
   logic           rsp_overflow_ff, rsp_overflow_in;

   logic           dp_we;
   logic [CW-1:0]  dp_waddr;
   logic [DW-1:0]  dp_wdata;
   logic [CW-1:0]  dp_raddr;
   logic [DW-1:0]  dp_rd;
   logic           ref_we;
   logic [RA_W-1:0] ref_waddr;
   logic [RA_W-1:0] ref_raddr;
   logic [CHW-1:0] ref_rd;
   logic [CW-1:0]  col_m1;

   logic           calc_start;
   logic           calc_done;
   logic [SW-1:0]  calc_sim;

   logic [DW-1:0]  cost_up;
   logic [DW-1:0]  cost_left;
   logic [DW-1:0]  cost_diag;
   logic [DW-1:0]  best;

   // reference characters
   edsim_ram #(
      .WIDTH (CHW),
      .DEPTH (MAX_LEN),
      .AW    (RA_W)
   ) u_ref_mem (
      .clock   (clock),
      .wr_en   (ref_we),
      .wr_addr (ref_waddr),
      .wr_data (req_char_code),
      .rd_addr (ref_raddr),
      .rd_data (ref_rd)
   );

   // dp row, one cell per reference column
   edsim_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_LEN + 1),
      .AW    (CW)
   ) u_dp_mem (
      .clock   (clock),
      .wr_en   (dp_we),
      .wr_addr (dp_waddr),
      .wr_data (dp_wdata),
      .rd_addr (dp_raddr),
      .rd_data (dp_rd)
   );

   edsim_sim_calc #(
      .CW (CW),
      .DW (DW)
   ) u_sim_calc (
      .clock     (clock),
      .reset     (reset),
      .start     (calc_start),
      .edit_dist (dist_ff),
      .maxlen    (maxlen_ff),
      .done      (calc_done),
      .sim       (calc_sim)
   );

   // cell update: min of up + 1, left + 1, diagonal + mismatch
   always_comb begin
      cost_up   = dp_rd + DW'(1);
      cost_left = left_ff + DW'(1);
      cost_diag = diag_ff + ((ref_rd == char_ff) ? DW'(0) : DW'(1));
      best      = cost_up;
      if (cost_left < best) begin
         best = cost_left;
      end
      if (cost_diag < best) begin
         best = cost_diag;
      end
   end

   always_comb begin
      state_in         = state_ff;
      col_in           = col_ff;
      issue_done_in    = issue_done_ff;
      rvld_in          = 1'b0;
      rcol_in          = col_ff;
      left_in          = left_ff;
      diag_in          = diag_ff;
      ref_len_in       = ref_len_ff;
      q_len_in         = q_len_ff;
      ovf_in           = ovf_ff;
      char_in          = char_ff;
      dist_in          = dist_ff;
      maxlen_in        = maxlen_ff;
      sim_valid_in     = sim_valid_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_distance_in  = rsp_distance_ff;
      rsp_sim_in       = rsp_sim_ff;
      rsp_sim_valid_in = rsp_sim_valid_ff;
      rsp_overflow_in  = rsp_overflow_ff;
      dp_we            = 1'b0;
      dp_waddr         = col_ff;
      dp_wdata         = DW'(col_ff);
      dp_raddr         = col_ff;
      ref_we           = 1'b0;
      ref_waddr        = ref_len_ff[RA_W-1:0];
      col_m1           = col_ff - CW'(1);
      ref_raddr        = col_m1[RA_W-1:0];
      calc_start       = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_SWEEP: begin
            dp_we = 1'b1;
            if (col_ff == LEN_MAX) begin
               state_in = ST_IDLE;
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  edsim_pkg::MODE_APPEND: begin
                     if (ref_len_ff == LEN_MAX) begin
                        ovf_in = 1'b1;
                     end else begin
                        ref_we     = 1'b1;
                        ref_len_in = ref_len_ff + CW'(1);
                     end
                  end
                  edsim_pkg::MODE_QUERY: begin
                     if (q_len_ff == LEN_MAX) begin
                        ovf_in = 1'b1;
                     end else begin
                        q_len_in      = q_len_ff + CW'(1);
                        char_in       = req_char_code;
                        col_in        = '0;
                        issue_done_in = 1'b0;
                        state_in      = ST_FEED;
                     end
                  end
                  edsim_pkg::MODE_FINISH: begin
                     state_in = ST_FIN_RD;
                  end
                  edsim_pkg::MODE_CLEAR: begin
                     ref_len_in = '0;
                     col_in     = CW'(1);
                     state_in   = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FEED: begin
            // issue reads of cell j and reference char j-1
            if (!issue_done_ff) begin
               rvld_in = 1'b1;
               rcol_in = col_ff;
               if (col_ff == ref_len_ff) begin
                  issue_done_in = 1'b1;
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
            // write back the cell whose read data has arrived
            if (rvld_ff) begin
               dp_we    = 1'b1;
               dp_waddr = rcol_ff;
               diag_in  = dp_rd;
               if (rcol_ff == '0) begin
                  dp_wdata = DW'(q_len_ff);
                  left_in  = DW'(q_len_ff);
               end else begin
                  dp_wdata = best;
                  left_in  = best;
               end
               if (rcol_ff == ref_len_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FIN_RD: begin
            dp_raddr = ref_len_ff;
            state_in = ST_FIN_D;
         end
         ST_FIN_D: begin
            dist_in      = dp_rd;
            maxlen_in    = (ref_len_ff > q_len_ff) ? ref_len_ff : q_len_ff;
            sim_valid_in = (ref_len_ff != '0) || (q_len_ff != '0);
            state_in     = ST_CALC_GO;
         end
         ST_CALC_GO: begin
            calc_start = 1'b1;
            state_in   = ST_CALC;
         end
         ST_CALC: begin
            if (calc_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_distance_in  = DOW'(dist_ff);
               rsp_sim_in       = calc_sim;
               rsp_sim_valid_in = sim_valid_ff;
               rsp_overflow_in  = ovf_ff;
               q_len_in         = '0;
               col_in           = '0;
               state_in         = ST_SWEEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         col_ff        <= '0;
         issue_done_ff <= 1'b1;
         rvld_ff       <= 1'b0;
         ref_len_ff    <= '0;
         q_len_ff      <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         issue_done_ff <= issue_done_in;
         rvld_ff       <= rvld_in;
         ref_len_ff    <= ref_len_in;
         q_len_ff      <= q_len_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rcol_ff          <= rcol_in;
      left_ff          <= left_in;
      diag_ff          <= diag_in;
      char_ff          <= char_in;
      dist_ff          <= dist_in;
      maxlen_ff        <= maxlen_in;
      sim_valid_ff     <= sim_valid_in;
      rsp_distance_ff  <= rsp_distance_in;
      rsp_sim_ff       <= rsp_sim_in;
      rsp_sim_valid_ff <= rsp_sim_valid_in;
      rsp_overflow_ff  <= rsp_overflow_in;
   end

   assign req_stall                 = (state_ff != ST_IDLE);
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_distance              = rsp_distance_ff;
   assign rsp_similarity_hundredths = rsp_sim_ff;
   assign rsp_similarity_valid      = rsp_sim_valid_ff;
   assign rsp_overflow              = rsp_overflow_ff;

endmodule

// File: tb/edsim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edsim_checker
// watches both channels of the edit distance similarity unit, keeps its own
// copy of the reference string, query length and dp row, predicts the score
// of every finish request and compares each returned result field by field
// with the oldest predicted score
// ----------------------------------------------------------------------------

module edsim_checker #(
   parameter int MAX_LEN = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [1:0]                        req_mode,
   input  logic [edsim_pkg::CHAR_W-1:0]      req_char_code,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [edsim_pkg::DIST_W-1:0]      rsp_distance,
   input  logic [edsim_pkg::SIM_W-1:0]       rsp_similarity_hundredths,
   input  logic                              rsp_similarity_valid,
   input  logic                              rsp_overflow,
   output int                                fail_count,
   output int                                scores_waiting
);

   localparam int CHAR_W = edsim_pkg::CHAR_W;
   localparam int DIST_W = edsim_pkg::DIST_W;
   localparam int SIM_W  = edsim_pkg::SIM_W;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [SIM_W-1:0]  similarity;
      logic              sim_valid;
      logic              overflow;
   } score_type;

   logic [CHAR_W-1:0] ref_string [MAX_LEN];
   logic [DIST_W-1:0] edit_row [MAX_LEN+1];
   int                ref_len;
   int                query_len;
   logic              overflow_seen;
   score_type         expected_scores [$];
   int                errors = 0;

   function automatic void reset_row(int first);
      for (int j = first; j <= MAX_LEN; j++) begin
         edit_row[j] = DIST_W'(j);
      end
   endfunction

   // one pass over the row for the next query character
   task automatic take_query_char(logic [CHAR_W-1:0] code);
      int diag;
      int up;
      int best;
      int cost;
      if (query_len >= MAX_LEN) begin
         overflow_seen = 1'b1;
         return;
      end
      query_len++;
      diag = edit_row[0];
      edit_row[0] = DIST_W'(query_len);
      for (int j = 1; j <= ref_len; j++) begin
         up = edit_row[j];
         best = up + 1;
         if (int'(edit_row[j-1]) + 1 < best) begin
            best = int'(edit_row[j-1]) + 1;
         end
         cost = (ref_string[j-1] == code) ? 0 : 1;
         if (diag + cost < best) begin
            best = diag + cost;
         end
         diag = up;
         edit_row[j] = DIST_W'(best);
      end
   endtask

   // score of the current pair, then the query starts afresh
   function automatic score_type finish_score();
      score_type s;
      int        d;
      int        longest;
      d = edit_row[ref_len];
      longest = (ref_len > query_len) ? ref_len : query_len;
      s.distance = DIST_W'(d);
      s.overflow = overflow_seen;
      if (longest == 0) begin
         s.sim_valid = 1'b0;
         s.similarity = '0;
      end else begin
         s.sim_valid = 1'b1;
         if (d > longest) begin
            s.similarity = '0;
         end else begin
            s.similarity = SIM_W'((int'(edsim_pkg::SIM_SCALE) * (longest - d)) / longest);
         end
      end
      query_len = 0;
      reset_row(0);
      return s;
   endfunction

   task automatic apply_request(edsim_pkg::mode_type mode, logic [CHAR_W-1:0] code);
      case (mode)
         edsim_pkg::MODE_APPEND: begin
            if (ref_len >= MAX_LEN) begin
               overflow_seen = 1'b1;
            end else begin
               ref_string[ref_len] = code;
               ref_len++;
            end
         end
         edsim_pkg::MODE_QUERY: begin
            take_query_char(code);
         end
         edsim_pkg::MODE_CLEAR: begin
            ref_len = 0;
            reset_row(1);
         end
         default: begin
            expected_scores.insert(expected_scores.size(), finish_score());
         end
      endcase
   endtask

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $error("%s: expected %0d, actual %0d", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      score_type want;
      if (reset) begin
         ref_len = 0;
         query_len = 0;
         overflow_seen = 1'b0;
         reset_row(0);
         expected_scores.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_scores.size() == 0) begin
               errors++;
               $error("unexpected result: distance %0d, similarity %0d",
                      rsp_distance, rsp_similarity_hundredths);
            end else begin
               want = expected_scores.pop_front();
               check_field("distance", want.distance, rsp_distance);
               check_field("similarity_hundredths", want.similarity,
                           rsp_similarity_hundredths);
               check_field("similarity_valid", want.sim_valid, rsp_similarity_valid);
               check_field("overflow", want.overflow, rsp_overflow);
            end
         end
         if (req_valid && !req_stall) begin
            apply_request(edsim_pkg::mode_type'(req_mode), req_char_code);
         end
      end
      fail_count <= errors;
      scores_waiting <= expected_scores.size();
   end

endmodule

// File: tb/edit_distance_similarity_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_similarity_unit_tb
// regression for the edit distance similarity unit: a directed opening on
// empty strings, exact and near matches and a reference cleared mid-query,
// then random reference and query words drawn from small alphabets with
// mutated copies, bursts of stray requests, and a fill of both strings past
// their limit, then four word pairs. both channels idle and stall at random.
// ----------------------------------------------------------------------------

module edit_distance_similarity_unit_tb;

   localparam int CHAR_W        = edsim_pkg::CHAR_W;
   localparam int DIST_W        = edsim_pkg::DIST_W;
   localparam int SIM_W         = edsim_pkg::SIM_W;
   localparam int MAX_LEN       = 64;
   localparam int RANDOM_TARGET = 300;
   localparam int DRAIN_CYCLES  = 200;
   localparam int CYCLE_LIMIT   = 600000;
   localparam logic [CHAR_W-1:0] CODE_TOP = 21'h10FFFF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_mode = edsim_pkg::MODE_APPEND;
   logic [CHAR_W-1:0] req_char_code = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b1;
   logic [DIST_W-1:0] rsp_distance;
   logic [SIM_W-1:0]  rsp_similarity_hundredths;
   logic              rsp_similarity_valid;
   logic              rsp_overflow;

   int                fail_count;
   int                scores_waiting;
   int                cycle_count = 0;
   int                requests_sent = 0;
   int                sink_wait = 0;
   int                ref_fill = 0;
   bit                steady = 1'b0;
   logic [CHAR_W-1:0] alphabet [4];

   edit_distance_similarity_unit #(
      .MAX_LEN(MAX_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance),
      .rsp_similarity_hundredths(rsp_similarity_hundredths),
      .rsp_similarity_valid(rsp_similarity_valid),
      .rsp_overflow(rsp_overflow)
   );

   edsim_checker #(
      .MAX_LEN(MAX_LEN)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance),
      .rsp_similarity_hundredths(rsp_similarity_hundredths),
      .rsp_similarity_valid(rsp_similarity_valid),
      .rsp_overflow(rsp_overflow),
      .fail_count(fail_count),
      .scores_waiting(scores_waiting)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("edit_distance_similarity_unit regression: fail");
         $finish;
      end
   end

   // result side: a fresh stall count per result, counted down while valid
   always @(posedge clock) begin
      int draw;
      draw = steady ? 0 : $urandom_range(0, 17);
      if (reset || (rsp_valid && !rsp_stall)) begin
         sink_wait <= draw;
         rsp_stall <= (draw != 0);
      end else if (rsp_valid && sink_wait != 0) begin
         sink_wait <= sink_wait - 1;
         rsp_stall <= (sink_wait > 1);
      end
   end

   task automatic send_request(edsim_pkg::mode_type mode, logic [CHAR_W-1:0] code);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_char_code <= code;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      if (mode == edsim_pkg::MODE_APPEND) begin
         ref_fill++;
      end else if (mode == edsim_pkg::MODE_CLEAR) begin
         ref_fill = 0;
      end
   endtask

   function automatic logic [CHAR_W-1:0] any_code();
      return CHAR_W'($urandom_range(0, 1114111));
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char();
      if ($urandom_range(0, 4) == 0) begin
         return any_code();
      end
      return alphabet[$urandom_range(0, 3)];
   endfunction

   // reference word, then a query that is either a mutated copy or fresh
   task automatic run_word_pair(int ref_count, int query_count);
      logic [CHAR_W-1:0] word [$];
      logic [CHAR_W-1:0] c;
      int                r;
      for (int k = 0; k < 4; k++) begin
         alphabet[k] = any_code();
      end
      if (ref_fill + ref_count > MAX_LEN - 8 || $urandom_range(0, 2) != 0) begin
         send_request(edsim_pkg::MODE_CLEAR, any_code());
      end
      for (int i = 0; i < ref_count; i++) begin
         c = pick_char();
         word.insert(word.size(), c);
         send_request(edsim_pkg::MODE_APPEND, c);
      end
      if ($urandom_range(0, 1) == 0) begin
         foreach (word[i]) begin
            r = $urandom_range(0, 9);
            if (r == 1) begin
               send_request(edsim_pkg::MODE_QUERY, pick_char());
            end else if (r == 2) begin
               send_request(edsim_pkg::MODE_QUERY, word[i]);
               send_request(edsim_pkg::MODE_QUERY, pick_char());
            end else if (r != 0) begin
               send_request(edsim_pkg::MODE_QUERY, word[i]);
            end
         end
      end else begin
         repeat (query_count) send_request(edsim_pkg::MODE_QUERY, pick_char());
      end
      send_request(edsim_pkg::MODE_FINISH, any_code());
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // both strings empty, then a query against an empty reference
      send_request(edsim_pkg::MODE_FINISH, 21'h000000);
      send_request(edsim_pkg::MODE_QUERY, 21'h000000);
      send_request(edsim_pkg::MODE_FINISH, CODE_TOP);

      send_request(edsim_pkg::MODE_APPEND, 21'h000000);
      send_request(edsim_pkg::MODE_APPEND, CODE_TOP);
      send_request(edsim_pkg::MODE_APPEND, 21'h0AAAAA);
      send_request(edsim_pkg::MODE_APPEND, 21'h055555);

      // exact match
      send_request(edsim_pkg::MODE_QUERY, 21'h000000);
      send_request(edsim_pkg::MODE_QUERY, CODE_TOP);
      send_request(edsim_pkg::MODE_QUERY, 21'h0AAAAA);
      send_request(edsim_pkg::MODE_QUERY, 21'h055555);
      send_request(edsim_pkg::MODE_FINISH, 21'h000000);

      // one character missing
      send_request(edsim_pkg::MODE_QUERY, 21'h000000);
      send_request(edsim_pkg::MODE_QUERY, CODE_TOP);
      send_request(edsim_pkg::MODE_QUERY, 21'h055555);
      send_request(edsim_pkg::MODE_FINISH, 21'h000000);

      // reference cleared and regrown while a query is open
      send_request(edsim_pkg::MODE_QUERY, 21'h0AAAAA);
      send_request(edsim_pkg::MODE_CLEAR, CODE_TOP);
      send_request(edsim_pkg::MODE_APPEND, 21'h0AAAAA);
      send_request(edsim_pkg::MODE_QUERY, 21'h0AAAAA);
      send_request(edsim_pkg::MODE_FINISH, 21'h000000);
      send_request(edsim_pkg::MODE_CLEAR, 21'h000000);

      while (requests_sent < RANDOM_TARGET) begin
         steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 6) == 0) begin
            // stray requests in any order
            repeat ($urandom_range(1, 6)) begin
               send_request(edsim_pkg::mode_type'($urandom_range(0, 3)), pick_char());
            end
         end else if ($urandom_range(0, 9) == 0) begin
            run_word_pair($urandom_range(11, 24), $urandom_range(11, 24));
         end else begin
            run_word_pair($urandom_range(0, 10), $urandom_range(0, 10));
         end
      end

      // both strings filled past their limit, overflow stays set afterwards
      steady = 1'b0;
      send_request(edsim_pkg::MODE_CLEAR, any_code());
      repeat (MAX_LEN + 3) send_request(edsim_pkg::MODE_APPEND, pick_char());
      repeat (MAX_LEN + 3) send_request(edsim_pkg::MODE_QUERY, pick_char());
      send_request(edsim_pkg::MODE_FINISH, any_code());
      send_request(edsim_pkg::MODE_CLEAR, any_code());
      send_request(edsim_pkg::MODE_FINISH, any_code());
      repeat (4) run_word_pair($urandom_range(0, 8), $urandom_range(0, 8));

      req_valid <= 1'b0;
      while (scores_waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && scores_waiting == 0) begin
         $display("edit_distance_similarity_unit regression: pass");
      end else begin
         $display("edit_distance_similarity_unit regression: fail");
      end
      $finish;
   end

endmodule
